/* hdl/gtu_pkg.sv */
// Package for the GSM 7-bit to UTF-8 converter: queue entry types, the
// default and extension code tables, and the UTF-8 encoder function.
// Depends on nothing; every other file but gtu_checker imports it.
package gtu_pkg;

    localparam int GTU_QUEUE_DEPTH = 4;
    localparam logic [7:0] GTU_ESC_CODE = 8'h1B;

    // One converted character: up to three UTF-8 bytes, first byte in slot 0.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } t_entry;

    // Write request from the front end into the queue.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic        hit;
        logic [15:0] point;
    } t_lookup;

    // Extension table, used for the byte that follows an escape.
    function automatic t_lookup ext_lookup(input logic [7:0] code);
        t_lookup r;
        r.hit   = 1'b1;
        r.point = 16'h0000;
        unique case (code)
            8'h0A: r.point = 16'h000C;
            8'h14: r.point = 16'h005E;
            8'h1B: r.point = 16'h0020;
            8'h28: r.point = 16'h007B;
            8'h29: r.point = 16'h007D;
            8'h2F: r.point = 16'h005C;
            8'h3C: r.point = 16'h005B;
            8'h3D: r.point = 16'h007E;
            8'h3E: r.point = 16'h005D;
            8'h40: r.point = 16'h007C;
            8'h65: r.point = 16'h20AC;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Default alphabet; codes missing from the table pass through unchanged.
    function automatic logic [15:0] def_point(input logic [7:0] code);
        logic [15:0] p;
        p = {8'h00, code};
        unique case (code)
            8'h00: p = 16'h0040;
            8'h01: p = 16'h00A3;
            8'h02: p = 16'h0024;
            8'h03: p = 16'h00A5;
            8'h04: p = 16'h00E8;
            8'h05: p = 16'h00E9;
            8'h06: p = 16'h00F9;
            8'h07: p = 16'h00EC;
            8'h08: p = 16'h00F2;
            8'h09: p = 16'h00C7;
            8'h0B: p = 16'h00D8;
            8'h0C: p = 16'h00F8;
            8'h0E: p = 16'h00C5;
            8'h0F: p = 16'h00E5;
            8'h10: p = 16'h0394;
            8'h11: p = 16'h005F;
            8'h12: p = 16'h03A6;
            8'h13: p = 16'h0393;
            8'h14: p = 16'h039B;
            8'h15: p = 16'h03A9;
            8'h16: p = 16'h03A0;
            8'h17: p = 16'h03A8;
            8'h18: p = 16'h03A3;
            8'h19: p = 16'h0398;
            8'h1A: p = 16'h039E;
            8'h1C: p = 16'h00C6;
            8'h1D: p = 16'h00E6;
            8'h1E: p = 16'h00DF;
            8'h1F: p = 16'h00C9;
            8'h24: p = 16'h00A4;
            8'h40: p = 16'h00A1;
            8'h5B: p = 16'h00C4;
            8'h5C: p = 16'h00D6;
            8'h5D: p = 16'h00D1;
            8'h5E: p = 16'h00DC;
            8'h5F: p = 16'h00A7;
            8'h60: p = 16'h00BF;
            8'h7B: p = 16'h00E4;
            8'h7C: p = 16'h00F6;
            8'h7D: p = 16'h00F1;
            8'h7E: p = 16'h00FC;
            8'h7F: p = 16'h00E0;
            default: p = {8'h00, code};
        endcase
        return p;
    endfunction

    // UTF-8 encoding of a code point in the basic plane.
    function automatic t_entry utf8_encode(input logic [15:0] p);
        t_entry e;
        e.count = 2'd1;
        e.bytes = '0;
        if (p < 16'h0080) begin
            e.count    = 2'd1;
            e.bytes[0] = p[7:0];
        end else if (p < 16'h0800) begin
            e.count    = 2'd2;
            e.bytes[0] = {3'b110, p[10:6]};
            e.bytes[1] = {2'b10, p[5:0]};
        end else begin
            e.count    = 2'd3;
            e.bytes[0] = {4'b1110, p[15:12]};
            e.bytes[1] = {2'b10, p[11:6]};
            e.bytes[2] = {2'b10, p[5:0]};
        end
        return e;
    endfunction

endpackage

/* hdl/gtu_front.sv */
// Front end of the converter: accepts GSM bytes, tracks the escape prefix,
// looks the code up and encodes it. Depends on gtu_pkg.
module gtu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,
    input  logic           i_s_axis_tlast,
    input  logic           i_q_full,
    output gtu_pkg::t_push o_push
);
    import gtu_pkg::*;

    logic    r_esc_pending;
    logic    n_esc_pending;
    logic    accept;
    t_lookup ext;
    logic    emit;

    assign o_s_axis_tready = !i_q_full;
    assign accept          = i_s_axis_tvalid && !i_q_full;
    assign ext             = ext_lookup(i_s_axis_tdata);

    always_comb begin
        n_esc_pending = r_esc_pending;
        emit          = 1'b0;
        o_push.entry  = utf8_encode(def_point(i_s_axis_tdata));
        if (r_esc_pending) begin
            emit         = ext.hit;
            o_push.entry = utf8_encode(ext.point);
        end else if (i_s_axis_tdata != GTU_ESC_CODE) begin
            emit = 1'b1;
        end
        if (accept) begin
            n_esc_pending = !r_esc_pending && (i_s_axis_tdata == GTU_ESC_CODE)
                            && !i_s_axis_tlast;
        end
        o_push.valid = accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
        end else begin
            r_esc_pending <= n_esc_pending;
        end
    end

endmodule

/* hdl/gtu_queue.sv */
// Short queue of encoded characters between the front end and the byte
// serializer. Depends on gtu_pkg.
module gtu_queue #(
    parameter int DEPTH = gtu_pkg::GTU_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gtu_pkg::t_push  i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output gtu_pkg::t_entry o_head
);
    import gtu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/gtu_back.sv */
// Back end: sends the bytes of each queued character one per cycle unless
// stalled, through a registered output stage. Depends on gtu_pkg.
module gtu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  gtu_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,
    output logic            o_m_axis_tlast
);
    import gtu_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       load;
    logic       is_last;

    assign load    = i_head_valid && (!r_out_valid || i_m_axis_tready);
    assign is_last = (r_idx == i_head.count - 2'd1);
    assign o_pop   = load && is_last;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= i_head.bytes[r_idx];
            r_out_last <= is_last;
        end
    end

endmodule

/* hdl/gsm7_to_utf8_converter_unit.sv */
// Top level of the GSM 7-bit default alphabet to UTF-8 converter.
// Depends on gtu_pkg, gtu_front, gtu_queue and gtu_back.
//
//  Channel  | Direction | tdata (LSB up) | tlast
//  s_axis   | in        | gsm_byte[7:0]  | end_of_message
//  m_axis   | out       | utf8_byte[7:0] | last_byte
//
// The input side takes one GSM byte per cycle while the queue has room; the
// output side sends one UTF-8 byte per cycle while the sink is ready, so a
// character takes one byte for ASCII, two for Latin and Greek letters and
// three for the euro sign; the single-byte output port sets the character
// rate. A character's first byte passes the queue, then the output register.
// Reset is synchronous and active low; it clears the escape flag, the queue
// and the output valid flag. Either side can stall on its own: the queue
// absorbs up to QUEUE_DEPTH characters before the input stops accepting.
module gsm7_to_utf8_converter_unit #(
    parameter int QUEUE_DEPTH = gtu_pkg::GTU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] gsm_byte
    input  logic       i_s_axis_tlast,   // end_of_message
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] utf8_byte
    output logic       o_m_axis_tlast    // last_byte
);
    import gtu_pkg::*;

    t_push  push;
    logic   q_full;
    logic   pop;
    logic   head_valid;
    t_entry head;

    // Front end: escape tracking, table lookup and encoding in the accept
    // cycle. A request that produces no character (an escape, or an unknown
    // extension code) is consumed without a queue write.
    gtu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (q_full),
        .o_push          (push)
    );

    // Queue of encoded characters between the two sides.
    gtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Back end: byte serializer with a registered output.
    gtu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

/* hdl/gtu_checker.sv */
// Port checker for the converter top level, attached by the bind below.
// Depends only on the ports of gsm7_to_utf8_converter_unit.
module gtu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    a_ascii_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[7] |-> o_m_axis_tlast)
        else $error("single-byte character not marked last");

    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[7] && o_m_axis_tdata[6] |-> !o_m_axis_tlast)
        else $error("lead byte marked last");

    a_continuation_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tdata[7] && !o_m_axis_tdata[6])
        else $error("continuation byte missing inside a character");

endmodule

bind gsm7_to_utf8_converter_unit gtu_checker u_gtu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* verif/gtu_stream_checker.sv */
// Stream checker for the GSM 7-bit to UTF-8 converter: it predicts the UTF-8
// bytes of every accepted GSM request and compares them with the output stream.
// Depends on gtu_pkg for the escape code only.
module gtu_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] gsm_byte
    input  logic       i_in_last,    // end_of_message
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [7:0] utf8_byte
    input  logic       i_out_last,   // last_byte
    output int         o_fail_count,
    output int         o_pending_count
);
    import gtu_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_utf8_byte;

    t_utf8_byte utf8_expected_q [$];
    logic       escape_seen = 1'b0;
    int         fails       = 0;

    // Maps {extension, code} to {hit, code point}. Extension codes that are
    // not in the table miss; default codes not in the table pass through.
    function automatic logic [16:0] map_code(input logic ext, input logic [7:0] code);
        case ({ext, code})
            9'h10A: return 17'h1000C;
            9'h114: return 17'h1005E;
            9'h11B: return 17'h10020;
            9'h128: return 17'h1007B;
            9'h129: return 17'h1007D;
            9'h12F: return 17'h1005C;
            9'h13C: return 17'h1005B;
            9'h13D: return 17'h1007E;
            9'h13E: return 17'h1005D;
            9'h140: return 17'h1007C;
            9'h165: return 17'h120AC;
            9'h000: return 17'h10040;
            9'h001: return 17'h100A3;
            9'h002: return 17'h10024;
            9'h003: return 17'h100A5;
            9'h004: return 17'h100E8;
            9'h005: return 17'h100E9;
            9'h006: return 17'h100F9;
            9'h007: return 17'h100EC;
            9'h008: return 17'h100F2;
            9'h009: return 17'h100C7;
            9'h00B: return 17'h100D8;
            9'h00C: return 17'h100F8;
            9'h00E: return 17'h100C5;
            9'h00F: return 17'h100E5;
            9'h010: return 17'h10394;
            9'h011: return 17'h1005F;
            9'h012: return 17'h103A6;
            9'h013: return 17'h10393;
            9'h014: return 17'h1039B;
            9'h015: return 17'h103A9;
            9'h016: return 17'h103A0;
            9'h017: return 17'h103A8;
            9'h018: return 17'h103A3;
            9'h019: return 17'h10398;
            9'h01A: return 17'h1039E;
            9'h01C: return 17'h100C6;
            9'h01D: return 17'h100E6;
            9'h01E: return 17'h100DF;
            9'h01F: return 17'h100C9;
            9'h024: return 17'h100A4;
            9'h040: return 17'h100A1;
            9'h05B: return 17'h100C4;
            9'h05C: return 17'h100D6;
            9'h05D: return 17'h100D1;
            9'h05E: return 17'h100DC;
            9'h05F: return 17'h100A7;
            9'h060: return 17'h100BF;
            9'h07B: return 17'h100E4;
            9'h07C: return 17'h100F6;
            9'h07D: return 17'h100F1;
            9'h07E: return 17'h100FC;
            9'h07F: return 17'h100E0;
            default: return ext ? 17'h00000 : {1'b1, 8'h00, code};
        endcase
    endfunction

    // Queues the one to three UTF-8 bytes of a code point, last one marked.
    function automatic void queue_utf8(input logic [15:0] cp);
        if (cp < 16'h0080) begin
            utf8_expected_q.push_back({cp[7:0], 1'b1});
        end else if (cp < 16'h0800) begin
            utf8_expected_q.push_back({3'b110, cp[10:6], 1'b0});
            utf8_expected_q.push_back({2'b10, cp[5:0], 1'b1});
        end else begin
            utf8_expected_q.push_back({4'b1110, cp[15:12], 1'b0});
            utf8_expected_q.push_back({2'b10, cp[11:6], 1'b0});
            utf8_expected_q.push_back({2'b10, cp[5:0], 1'b1});
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_utf8_byte  want;
        logic [16:0] hit_cp;
        if (!i_rst_n) begin
            escape_seen = 1'b0;
            utf8_expected_q.delete();
        end else begin
            // A byte leaving at this edge cannot stem from a request taken at
            // the same edge, so the output side is checked first.
            if (i_out_valid && i_out_ready) begin
                if (utf8_expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected UTF-8 byte %02h last %0b", i_out_data, i_out_last);
                end else begin
                    want = utf8_expected_q.pop_front();
                    if (want.value !== i_out_data || want.last !== i_out_last) begin
                        fails++;
                        if (fails <= 10)
                            $display("UTF-8 byte: expected %02h last %0b, got %02h last %0b",
                                     want.value, want.last, i_out_data, i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (escape_seen) begin
                    escape_seen = 1'b0;
                    hit_cp = map_code(1'b1, i_in_data);
                    if (hit_cp[16])
                        queue_utf8(hit_cp[15:0]);
                end else if (i_in_data == GTU_ESC_CODE) begin
                    escape_seen = 1'b1;
                end else begin
                    hit_cp = map_code(1'b0, i_in_data);
                    queue_utf8(hit_cp[15:0]);
                end
                if (i_in_last)
                    escape_seen = 1'b0;
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= utf8_expected_q.size();
    end

endmodule

/* verif/tb_gsm7_to_utf8_converter_unit.sv */
// Testbench top for the GSM 7-bit to UTF-8 converter: it drives GSM requests
// with random gaps, stalls the output, and gives the verdict.
// Depends on gtu_pkg, gsm7_to_utf8_converter_unit and gtu_stream_checker.
module tb_gsm7_to_utf8_converter_unit;
    import gtu_pkg::*;

    // Extension codes that follow an escape; the euro sign is the only one
    // that needs three UTF-8 bytes.
    localparam logic [7:0]  EXT_EURO  = 8'h65;
    localparam logic [7:0]  EXT_BAR   = 8'h40;
    localparam logic [7:0]  EXT_FF    = 8'h0A;
    localparam logic [87:0] EXT_CODES = {8'h65, 8'h40, 8'h3E, 8'h3D, 8'h3C, 8'h2F,
                                         8'h29, 8'h28, 8'h1B, 8'h14, 8'h0A};
    localparam int          ITEM_GOAL = 310;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_data   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_data;
    logic       out_last;
    int         fail_count;
    int         pending_count;

    bit src_burst  = 1'b0;   // source sends back to back while set
    bit sink_burst = 1'b0;   // sink starts no new stall while set
    int sink_stall = 0;
    int items_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gsm7_to_utf8_converter_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tlast  (out_last)
    );

    gtu_stream_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_in_last       (in_last),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .i_out_last      (out_last),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Idle stretches come from two ranges; one draw in ten uses the long one.
    function automatic int idle_cycles();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Presents one GSM request and holds it until the converter takes it.
    // Valid is only lowered when a gap is wanted, so back-to-back requests
    // never see valid dropped and raised within one step.
    task automatic send_gsm(input logic [7:0] code, input logic eom);
        int gap;
        gap = 0;
        if (!src_burst && $urandom_range(0, 2) == 0)
            gap = idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= code;
        in_last  <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // The sink stalls at random; while the burst mode is on it starts no new
    // stall, then takes every byte, which drains the queue at full throughput.
    always @(posedge clk) begin
        if (sink_stall != 0) begin
            out_ready  <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            out_ready <= 1'b1;
            if (!sink_burst && $urandom_range(0, 3) == 0)
                sink_stall <= idle_cycles();
        end
        if ($urandom_range(0, 199) == 0)
            sink_burst <= ~sink_burst;
    end

    initial begin : stimulus
        int         msg_len;
        int         k;
        int         waited;
        logic       eom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the direct codes, table hits in Latin and Greek,
        // pass-through codes at both ends of the upper half, and every escape
        // case (euro, escape after escape, unknown extension, dangling escape).
        send_gsm(8'h00, 1'b0);
        send_gsm(8'h02, 1'b0);
        send_gsm(8'h11, 1'b0);
        send_gsm(8'h01, 1'b0);
        send_gsm(8'h10, 1'b0);
        send_gsm(8'hFF, 1'b0);
        send_gsm(8'h80, 1'b0);
        send_gsm(8'h7F, 1'b0);
        send_gsm(8'h41, 1'b1);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(EXT_EURO, 1'b0);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(8'h00, 1'b0);
        // An escape that ends a message must not turn the next byte into an
        // extension lookup.
        send_gsm(GTU_ESC_CODE, 1'b1);
        send_gsm(8'h14, 1'b0);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(EXT_BAR, 1'b0);
        send_gsm(EXT_BAR, 1'b0);
        send_gsm(GTU_ESC_CODE, 1'b0);
        send_gsm(EXT_FF, 1'b1);

        // Random part: messages of random length, mostly well-formed text
        // with escape sequences, plus broken escapes and stray end marks.
        while (items_sent < ITEM_GOAL) begin
            src_burst = ($urandom_range(0, 4) == 0);
            msg_len   = $urandom_range(1, 12);
            for (k = 0; k < msg_len; k++) begin
                eom = (k == msg_len - 1);
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // On the last byte of a message this leaves the
                        // escape dangling.
                        send_gsm(GTU_ESC_CODE, eom);
                        if (!eom)
                            send_gsm(EXT_CODES[8 * $urandom_range(0, 10) +: 8], 1'b0);
                    end
                    2: begin
                        send_gsm(GTU_ESC_CODE, 1'b0);
                        send_gsm(8'($urandom_range(0, 255)), eom);
                    end
                    3: send_gsm(8'($urandom_range(128, 255)), eom);
                    4: send_gsm(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    default: send_gsm(8'($urandom_range(0, 127)), eom);
                endcase
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every predicted byte, then go on waiting so that any
        // stray output would still be seen.
        waited = 0;
        while (pending_count != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("gsm7_to_utf8_converter_unit: match");
        end else begin
            $display("gsm7_to_utf8_converter_unit: mismatch");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("gsm7_to_utf8_converter_unit: mismatch");
        $finish;
    end

endmodule

/* gsm7_to_utf8_converter_unit.f */
hdl/gtu_pkg.sv
hdl/gtu_front.sv
hdl/gtu_queue.sv
hdl/gtu_back.sv
hdl/gsm7_to_utf8_converter_unit.sv
hdl/gtu_checker.sv
verif/gtu_stream_checker.sv
verif/tb_gsm7_to_utf8_converter_unit.sv
